// ===== rtl/core/mosl_pkg.sv =====
package mosl_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INC,
        S_MED,
        S_MEDW,
        S_OFS,
        S_SCAN,
        S_DRAIN,
        S_CMP,
        S_OUT
    } t_state;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_BASE_X = 3'd2;
    localparam logic [2:0] CFG_BASE_Y = 3'd3;
    localparam logic [2:0] CFG_RANGE  = 3'd4;

    typedef struct packed {
        logic        [8:0] width;
        logic        [8:0] height;
        logic signed [7:0] base_dx;
        logic signed [7:0] base_dy;
        logic        [7:0] range;
    } t_cfg;

    typedef struct packed {
        logic clr_step;
        logic take;
        logic inc;
        logic med_step;
        logic ofs_setup;
        logic scan_step;
        logic cmp;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic last_flag;
        logic scan_last;
        logic ofs_last;
    } t_sts;

endpackage

// ===== rtl/core/mosl_ctrl.sv =====
module mosl_ctrl
    import mosl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_INC;
                end
            end
            S_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = i_sts.last_flag ? S_MED : S_IDLE;
            end
            S_MED: begin
                o_cmd.med_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_MEDW;
                end
            end
            S_MEDW: begin
                n_state = S_OFS;
            end
            S_OFS: begin
                o_cmd.ofs_setup = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.ofs_last ? S_OUT : S_OFS;
            end
            S_OUT: begin
                o_done  = 1'b1;
                n_state = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/mosl_dp.sv =====
module mosl_dp
    import mosl_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_ref_pixel,
    input  logic [7:0]  i_tgt_pixel,
    input  logic        i_last_pixel,
    output t_sts        o_sts,
    output logic [8:0]  o_best_dx,
    output logic [8:0]  o_best_dy,
    output logic [16:0] o_mismatch_count
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int MXW   = (DW > HW) ? DW : HW;
    localparam int SW    = ((MXW > 9) ? MXW : 9) + 2;
    localparam int OFW   = 2 * SW;

    logic [7:0]      r_ref_mem [DEPTH];
    logic [7:0]      r_tgt_mem [DEPTH];
    logic [CNTW-1:0] r_ref_hist [256];
    logic [CNTW-1:0] r_tgt_hist [256];

    logic [DW-1:0]   w;
    logic [HW-1:0]   h;
    logic [CNTW-1:0] r_total;
    logic [CNTW-1:0] r_pcnt;
    logic [7:0]      r_rp, r_tp;
    logic            r_last;
    logic [CNTW-1:0] r_ref_hrd, r_tgt_hrd;
    logic [7:0]      hist_raddr_r, hist_raddr_t;
    logic [7:0]      r_sweep;

    logic            r_mvld;
    logic [7:0]      r_mv;
    logic [CNTW-1:0] r_rcum, r_tcum, n_rcum, n_tcum;
    logic            r_rfound, r_tfound;
    logic [7:0]      r_rmed, r_tmed;
    logic [CNTW-1:0] rank;

    logic [1:0]             r_gi, r_ki;
    logic signed [SW-1:0]   n_ox, n_oy, r_ox, r_oy, sc, sr;
    logic signed [OFW-1:0]  r_off;
    logic [XW-1:0]          r_j;
    logic [YW-1:0]          r_i;
    logic [AW-1:0]          r_raddr, taddr;
    logic                   pos_ok, r_pv;
    logic [7:0]             r_ref_rd, r_tgt_rd;
    logic signed [9:0]      r_rhi, r_rlo, r_thi, r_tlo, rps, tps;
    logic                   hit;
    logic [CNTW-1:0]        r_cnt, r_best_cnt;
    logic signed [SW-1:0]   r_best_x, r_best_y;

    always_comb begin
        if (i_cfg.width == 9'd0) begin
            w = DW'(1);
        end else if (32'(i_cfg.width) > MAX_WIDTH) begin
            w = DW'(MAX_WIDTH);
        end else begin
            w = DW'(i_cfg.width);
        end
        if (i_cfg.height == 9'd0) begin
            h = HW'(1);
        end else if (32'(i_cfg.height) > MAX_HEIGHT) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(i_cfg.height);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= CNTW'(w) * CNTW'(h);
    end

    // histogram read/modify/write and median sweep
    assign hist_raddr_r = i_cmd.take ? i_ref_pixel : r_sweep;
    assign hist_raddr_t = i_cmd.take ? i_tgt_pixel : r_sweep;

    always_ff @(posedge i_clk) begin
        r_ref_hrd <= r_ref_hist[hist_raddr_r];
        r_tgt_hrd <= r_tgt_hist[hist_raddr_t];
        if (i_cmd.clr_step) begin
            r_ref_hist[r_sweep] <= '0;
            r_tgt_hist[r_sweep] <= '0;
        end else if (i_cmd.inc && (r_pcnt < r_total)) begin
            r_ref_hist[r_rp] <= r_ref_hrd + CNTW'(1);
            r_tgt_hist[r_tp] <= r_tgt_hrd + CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.inc && (r_pcnt < r_total)) begin
            r_ref_mem[AW'(r_pcnt)] <= r_rp;
            r_tgt_mem[AW'(r_pcnt)] <= r_tp;
        end
        r_ref_rd <= r_ref_mem[r_raddr];
        r_tgt_rd <= r_tgt_mem[taddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rp   <= i_ref_pixel;
            r_tp   <= i_tgt_pixel;
            r_last <= i_last_pixel;
        end
    end

    assign rank   = r_pcnt >> 1;
    assign n_rcum = r_rcum + r_ref_hrd;
    assign n_tcum = r_tcum + r_tgt_hrd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= '0;
            r_pcnt   <= '0;
            r_mvld   <= 1'b0;
            r_rfound <= 1'b0;
            r_tfound <= 1'b0;
        end else begin
            r_mvld <= i_cmd.med_step;
            if (i_cmd.clr_step || i_cmd.med_step) begin
                r_sweep <= r_sweep + 8'd1;
            end
            if (i_cmd.clr_step) begin
                r_pcnt   <= '0;
                r_rfound <= 1'b0;
                r_tfound <= 1'b0;
            end else begin
                if (i_cmd.inc && (r_pcnt < r_total)) begin
                    r_pcnt <= r_pcnt + CNTW'(1);
                end
                if (r_mvld && !r_rfound && (n_rcum > rank)) begin
                    r_rfound <= 1'b1;
                end
                if (r_mvld && !r_tfound && (n_tcum > rank)) begin
                    r_tfound <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv <= r_sweep;
        if (i_cmd.clr_step) begin
            r_rcum <= '0;
            r_tcum <= '0;
            r_rmed <= 8'hFF;
            r_tmed <= 8'hFF;
        end else if (r_mvld) begin
            r_rcum <= n_rcum;
            r_tcum <= n_tcum;
            if (!r_rfound && (n_rcum > rank)) begin
                r_rmed <= r_mv;
            end
            if (!r_tfound && (n_tcum > rank)) begin
                r_tmed <= r_mv;
            end
        end
    end

    // offset search
    assign n_ox = SW'(i_cfg.base_dx) + signed'(SW'(r_gi)) - SW'(1);
    assign n_oy = SW'(i_cfg.base_dy) + signed'(SW'(r_ki)) - SW'(1);
    assign sc   = signed'(SW'(r_j)) - r_ox;
    assign sr   = signed'(SW'(r_i)) - r_oy;
    assign taddr  = AW'(signed'(OFW'(r_raddr)) - r_off);
    assign pos_ok = !sc[SW-1] && (sc < signed'(SW'(w)))
                 && !sr[SW-1] && (sr < signed'(SW'(h)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ofs_setup) begin
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_off   <= OFW'(n_oy) * OFW'(signed'(SW'(w))) + OFW'(n_ox);
            r_rhi   <= signed'({2'b00, r_rmed}) + signed'({2'b00, i_cfg.range});
            r_rlo   <= signed'({2'b00, r_rmed}) - signed'({2'b00, i_cfg.range});
            r_thi   <= signed'({2'b00, r_tmed}) + signed'({2'b00, i_cfg.range});
            r_tlo   <= signed'({2'b00, r_tmed}) - signed'({2'b00, i_cfg.range});
            r_i     <= '0;
            r_j     <= '0;
            r_raddr <= '0;
        end else if (i_cmd.scan_step) begin
            r_raddr <= r_raddr + AW'(1);
            if (DW'(r_j) == w - DW'(1)) begin
                r_j <= '0;
                r_i <= r_i + YW'(1);
            end else begin
                r_j <= r_j + XW'(1);
            end
        end
    end

    assign o_sts.scan_last = (DW'(r_j) == w - DW'(1)) && (HW'(r_i) == h - HW'(1));
    assign o_sts.ofs_last  = (r_gi == 2'd2) && (r_ki == 2'd2);
    assign o_sts.sweep_last = (r_sweep == 8'hFF);
    assign o_sts.last_flag  = r_last;

    assign rps = signed'({2'b00, r_ref_rd});
    assign tps = signed'({2'b00, r_tgt_rd});
    assign hit = ((r_ref_rd > r_rmed) != (r_tgt_rd > r_tmed))
              && ((rps > r_rhi) || (rps < r_rlo))
              && ((tps > r_thi) || (tps < r_tlo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_gi <= '0;
            r_ki <= '0;
        end else begin
            r_pv <= i_cmd.scan_step && pos_ok;
            if (i_cmd.cmp) begin
                if (r_gi == 2'd2) begin
                    r_gi <= '0;
                    r_ki <= (r_ki == 2'd2) ? 2'd0 : r_ki + 2'd1;
                end else begin
                    r_gi <= r_gi + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ofs_setup) begin
            r_cnt <= '0;
        end else if (r_pv && hit) begin
            r_cnt <= r_cnt + CNTW'(1);
        end
        if (i_cmd.cmp && (((r_gi == 2'd0) && (r_ki == 2'd0)) || (r_cnt < r_best_cnt))) begin
            r_best_cnt <= r_cnt;
            r_best_x   <= r_ox;
            r_best_y   <= r_oy;
        end
    end

    assign o_best_dx        = r_best_x[8:0];
    assign o_best_dy        = r_best_y[8:0];
    assign o_mismatch_count = 17'(r_best_cnt);

endmodule

// ===== rtl/core/mtb_offset_search_level_unit.sv =====
// channel   | signals                                         | dir
// pixel in  | start, busy, i_ref_pixel, i_tgt_pixel, i_last_pixel | in
// result    | o_done, o_best_dx, o_best_dy, o_mismatch_count  | out
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
// A pixel transfer reads the histogram, then increments it.
// After the last pixel: a median sweep, then a store scan for each of nine offsets,
// then the result.
// After reset and after each result the histograms are swept clear.
// The result strobe lasts one cycle; the receiver cannot stall it.
module mtb_offset_search_level_unit
    import mosl_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_ref_pixel,
    input  logic [7:0]  i_tgt_pixel,
    input  logic        i_last_pixel,
    output logic        o_done,
    output logic [8:0]  o_best_dx,
    output logic [8:0]  o_best_dy,
    output logic [16:0] o_mismatch_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= 9'd256;
            r_cfg.height  <= 9'd256;
            r_cfg.base_dx <= '0;
            r_cfg.base_dy <= '0;
            r_cfg.range   <= 8'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg.width   <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height  <= i_cfg_data;
                CFG_BASE_X: r_cfg.base_dx <= signed'(i_cfg_data[7:0]);
                CFG_BASE_Y: r_cfg.base_dy <= signed'(i_cfg_data[7:0]);
                CFG_RANGE:  r_cfg.range   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    mosl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    mosl_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .i_ref_pixel      (i_ref_pixel),
        .i_tgt_pixel      (i_tgt_pixel),
        .i_last_pixel     (i_last_pixel),
        .o_sts            (sts),
        .o_best_dx        (o_best_dx),
        .o_best_dy        (o_best_dy),
        .o_mismatch_count (o_mismatch_count)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result while idle");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transfer did not raise busy");
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (busy && !o_done)) else $error("no clear sweep after result");

endmodule
